FILE: hdl/ksq_pkg.sv
// Package for kth_smallest_quickselect: store geometry and sequencer types.
// No dependencies.
package ksq_pkg;
	localparam int MAX_ELEMENTS = 1024;
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int VW = 32;
	localparam int RW = 10;
	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic signed [VW-1:0] val_t;
endpackage

FILE: hdl/kth_smallest_quickselect.sv
// Top level of the rank selector: element store plus quickselect sequencer.
// Depends on ksq_pkg.
//
// channel  dir  contents
// s_axis   in   tdata = value[31:0], rank[41:32]; tlast = last
// m_axis   out  tdata = selected_value[31:0], used_rank[41:32], element_count[52:42],
//               overflowed[53]
//
// Loading: one word per cycle, s_axis_tready high only while loading.
// A compare-swap step runs through two store reads, compare, two writes and dispatch.
// Per window: a window check and 4 compare-swap steps, then a partition pass in which
// each element below the pivot is compared and each one moved up is swapped, a close,
// and a pivot swap step. Worst case is quadratic (equal values shrink the window by
// one). The result is read in ST_RES, registered in ST_RES2, held until m_axis_tready.
// Reset clears count and flags; the store is not cleared.
module kth_smallest_quickselect (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // value[31:0], rank[41:32], zero pad
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // selected_value, used_rank, element_count, overflowed
);
	import ksq_pkg::*;

	localparam logic [4:0] ST_LOAD = 5'd0, ST_WIN = 5'd1, ST_RDA = 5'd2, ST_RDB = 5'd3,
		ST_CMP = 5'd4, ST_WRA = 5'd5, ST_WRB = 5'd6, ST_NEXT = 5'd7, ST_PLOOP = 5'd8,
		ST_PCMP = 5'd9, ST_PRU = 5'd10, ST_PSWA = 5'd11, ST_PSWB = 5'd12,
		ST_PEND = 5'd13, ST_RES = 5'd14, ST_RES2 = 5'd15, ST_OUT = 5'd16;
	localparam logic [2:0] OP_LH = 3'd0, OP_LM = 3'd1, OP_MH = 3'd2, OP_SW = 3'd3,
		OP_UH = 3'd4, OP_END = 3'd5;

	logic [4:0] st_q;
	logic [2:0] op_q;
	val_t mem [MAX_ELEMENTS];
	val_t rd_q, a_q, b_q, piv_q, sel_q;
	cnt_t fill_q, cnt_out_q;
	logic ovf_q, ovf_out_q, swp_q;
	addr_t lo_q, hi_q, up_q, pos_q, ia_q, ib_q, want_q;
	logic [RW-1:0] used_q;
	logic we;
	addr_t wa, ra;
	val_t wd;
	logic in_acc, full;
	val_t in_val;
	logic [RW-1:0] in_rank;
	cnt_t cnt_n, lastidx;
	addr_t mid;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_val = s_axis_tdata[31:0];
	assign in_rank = s_axis_tdata[41:32];
	assign full = (fill_q == cnt_t'(MAX_ELEMENTS));
	assign cnt_n = full ? fill_q : fill_q + cnt_t'(1);
	assign lastidx = cnt_n - cnt_t'(1);
	assign mid = addr_t'((cnt_t'(lo_q) + cnt_t'(hi_q)) >> 1);

	assign s_axis_tready = (st_q == ST_LOAD);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = {2'd0, ovf_out_q, cnt_out_q, used_q, sel_q};

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// store port mux
	always_comb begin
		we = 1'b0;
		wa = ia_q;
		wd = b_q;
		ra = ia_q;
		unique case (st_q)
			ST_LOAD: begin
				we = in_acc && !full;
				wa = addr_t'(fill_q);
				wd = in_val;
			end
			ST_RDB: ra = ib_q;
			ST_WRA: we = swp_q;
			ST_WRB: begin
				we = swp_q;
				wa = ib_q;
				wd = a_q;
			end
			ST_PLOOP: ra = pos_q;
			ST_PRU: ra = up_q;
			ST_PSWA: begin
				we = 1'b1;
				wa = pos_q;
				wd = rd_q;
			end
			ST_PSWB: begin
				we = 1'b1;
				wa = up_q;
				wd = a_q;
			end
			ST_RES: ra = want_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			op_q <= OP_LH;
			fill_q <= '0;
			ovf_q <= 1'b0;
			cnt_out_q <= '0;
			ovf_out_q <= 1'b0;
			used_q <= '0;
			want_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			up_q <= '0;
			pos_q <= '0;
			ia_q <= '0;
			ib_q <= '0;
			a_q <= '0;
			b_q <= '0;
			piv_q <= '0;
			sel_q <= '0;
			swp_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (s_axis_tlast) begin
							fill_q <= '0;
							ovf_q <= 1'b0;
							cnt_out_q <= cnt_n;
							ovf_out_q <= ovf_q || full;
							if (cnt_t'(in_rank) >= lastidx) begin
								used_q <= RW'(lastidx);
								want_q <= addr_t'(lastidx);
							end else begin
								used_q <= in_rank;
								want_q <= addr_t'(in_rank);
							end
							lo_q <= '0;
							hi_q <= addr_t'(lastidx);
							st_q <= (cnt_n < cnt_t'(2)) ? ST_RES : ST_WIN;
						end else begin
							fill_q <= cnt_n;
							if (full) ovf_q <= 1'b1;
						end
					end
				end
				ST_WIN: begin
					if (cnt_t'(lo_q) + cnt_t'(1) < cnt_t'(hi_q)) begin
						op_q <= OP_LH;
						ia_q <= lo_q;
						ib_q <= hi_q;
						st_q <= ST_RDA;
					end else if (lo_q != hi_q) begin
						op_q <= OP_END;
						ia_q <= lo_q;
						ib_q <= hi_q;
						st_q <= ST_RDA;
					end else begin
						st_q <= ST_RES;
					end
				end
				ST_RDA: st_q <= ST_RDB;
				ST_RDB: begin
					a_q <= rd_q;
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					b_q <= rd_q;
					swp_q <= (op_q == OP_SW) || (op_q == OP_UH) || (a_q > rd_q);
					st_q <= ST_WRA;
				end
				ST_WRA: st_q <= ST_WRB;
				ST_WRB: st_q <= ST_NEXT;
				ST_NEXT: begin
					unique case (op_q)
						OP_LH: begin
							op_q <= OP_LM;
							ia_q <= lo_q;
							ib_q <= mid;
							st_q <= ST_RDA;
						end
						OP_LM: begin
							op_q <= OP_MH;
							ia_q <= mid;
							ib_q <= hi_q;
							st_q <= ST_RDA;
						end
						OP_MH: begin
							op_q <= OP_SW;
							ia_q <= mid;
							ib_q <= hi_q;
							st_q <= ST_RDA;
						end
						OP_SW: begin
							// old middle value now sits at hi
							piv_q <= a_q;
							up_q <= hi_q - addr_t'(1);
							pos_q <= lo_q;
							st_q <= ST_PLOOP;
						end
						OP_UH: begin
							if (up_q == want_q) begin
								st_q <= ST_RES;
							end else if (up_q < want_q) begin
								lo_q <= up_q + addr_t'(1);
								st_q <= ST_WIN;
							end else begin
								hi_q <= up_q - addr_t'(1);
								st_q <= ST_WIN;
							end
						end
						default: st_q <= ST_RES;
					endcase
				end
				ST_PLOOP: st_q <= (pos_q < up_q) ? ST_PCMP : ST_PEND;
				ST_PCMP: begin
					if (piv_q <= rd_q) begin
						a_q <= rd_q;
						st_q <= ST_PRU;
					end else begin
						pos_q <= pos_q + addr_t'(1);
						st_q <= ST_PLOOP;
					end
				end
				ST_PRU: st_q <= ST_PSWA;
				ST_PSWA: st_q <= ST_PSWB;
				ST_PSWB: begin
					up_q <= up_q - addr_t'(1);
					st_q <= ST_PLOOP;
				end
				ST_PEND: begin
					if (piv_q > rd_q) begin
						up_q <= up_q + addr_t'(1);
						ia_q <= up_q + addr_t'(1);
					end else begin
						ia_q <= up_q;
					end
					ib_q <= hi_q;
					op_q <= OP_UH;
					st_q <= ST_RDA;
				end
				ST_RES: st_q <= ST_RES2;
				ST_RES2: begin
					sel_q <= rd_q;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tready) st_q <= ST_LOAD;
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	property p_no_ready_out;
		@(posedge clk) disable iff (!arst_n) m_axis_tvalid |-> !s_axis_tready;
	endproperty
	a_no_ready_out: assert property (p_no_ready_out) else $error("ready during result");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cnt_t'(MAX_ELEMENTS)) else $error("fill overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_want_in_win: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WIN) |-> (lo_q <= want_q) && (want_q <= hi_q))
		else $error("rank outside window");
endmodule
